### rtl/sle_pkg.sv
// Shared types and codes for the sequential list engine.
package sle_pkg;

   localparam int CAPACITY = 128;
   localparam int ELEM_W   = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 8;

   localparam logic [2:0] ACT_CLEAR  = 3'd0;
   localparam logic [2:0] ACT_INSERT = 3'd1;
   localparam logic [2:0] ACT_DELETE = 3'd2;
   localparam logic [2:0] ACT_LOCATE = 3'd3;
   localparam logic [2:0] ACT_SORT   = 3'd4;
   localparam logic [2:0] ACT_READ   = 3'd5;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_POS   = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic [2:0]        action;
      logic [LEN_W-1:0]  position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data_out;
      logic [LEN_W-1:0]   found_index;
      logic [LEN_W-1:0]   length;
   } rsp_type;

endpackage

### rtl/sequential_list_engine.sv
// Top level: array-backed list with a memory sequencer for clear, insert, delete, locate, sort, read.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  req     | in        | req_valid / req_stall   | action, position, value
//  rsp     | out       | rsp_valid / rsp_stall   | status, data_out, found_index, length
//
// One request is in work at a time; req_stall is high from acceptance until the result is
// moved into the output register. The time per request is set by the single-port walk over
// the element memory: clear and unused codes need no walk, read fetches one entry, insert and
// delete read and write each moved entry, locate scans up to length, sort compares pairs.
// Reset empties the list at once; the element memory itself is never cleared.
// A stalled result holds in the output register while the next request is already taken.
module sequential_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sle_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sle_pkg::rsp_type rsp_payload
);
   import sle_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_FETCH    = 10'b00_0000_0010,
      S_MOVE_RD  = 10'b00_0000_0100,
      S_MOVE_WR  = 10'b00_0000_1000,
      S_INS_PUT  = 10'b00_0001_0000,
      S_SCAN     = 10'b00_0010_0000,
      S_SORT_LJ  = 10'b00_0100_0000,
      S_SORT_CMP = 10'b00_1000_0000,
      S_SORT_WJ  = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   // element memory: one write port, one registered read port
   elem_type           mem [CAPACITY];
   elem_type           rd_data_ff;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_en;
   elem_type           wr_data;

   state_type          state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff, rsp_payload_in;

   // working registers of the request in flight
   logic [2:0]         op_ff, op_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   elem_type           val_ff, val_in;
   logic [LEN_W-1:0]   j_ff, j_in;
   logic [LEN_W-1:0]   k_ff, k_in;
   elem_type           cur_ff, cur_in;
   elem_type           data_ff, data_in;
   logic [1:0]         status_ff, status_in;
   logic [LEN_W-1:0]   found_ff, found_in;

   logic [LEN_W-1:0]   j_inc, j_dec, j_inc2, k_inc, req_pos_m1, pos_m1, len_dec, len_inc;
   logic [LEN_W:0]     req_pos_x, len_x;
   logic               ins_bad, access_bad, list_full, rsp_take;

   assign j_inc      = j_ff + LEN_W'(1);
   assign j_dec      = j_ff - LEN_W'(1);
   assign j_inc2     = j_ff + LEN_W'(2);
   assign k_inc      = k_ff + LEN_W'(1);
   assign req_pos_m1 = req_payload.position - LEN_W'(1);
   assign pos_m1     = pos_ff - LEN_W'(1);
   assign len_dec    = len_ff - LEN_W'(1);
   assign len_inc    = len_ff + LEN_W'(1);
   assign req_pos_x  = {1'b0, req_payload.position};
   assign len_x      = {1'b0, len_ff};

   // position checks: insert allows one past the tail, delete and read only live entries
   assign ins_bad    = (req_payload.position == '0) || (req_pos_x > len_x + (LEN_W+1)'(1));
   assign access_bad = (req_payload.position == '0) || (req_payload.position > len_ff);
   assign list_full  = (len_ff == LEN_W'(CAPACITY));
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in       = state_ff;
      len_in         = len_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      op_in          = op_ff;
      pos_in         = pos_ff;
      val_in         = val_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      cur_in         = cur_ff;
      data_in        = data_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = val_ff;

      // drop the result once the consumer takes it
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // prefetch the addressed entry for delete/read, entry 0 for locate/sort
            if (req_payload.action inside {ACT_DELETE, ACT_READ}) begin
               rd_addr = req_pos_m1[ADDR_W-1:0];
            end
            if (req_valid) begin
               op_in     = req_payload.action;
               pos_in    = req_payload.position;
               val_in    = req_payload.value[ELEM_W-1:0];
               status_in = ST_OK;
               data_in   = '0;
               found_in  = '0;
               state_in  = S_DONE;
               case (req_payload.action)
                  ACT_CLEAR: begin
                     len_in = '0;
                  end
                  ACT_INSERT: begin
                     if (ins_bad) begin
                        status_in = ST_BAD_POS;
                     end else if (list_full) begin
                        status_in = ST_FULL;
                     end else begin
                        j_in = len_ff;
                        if (len_ff >= req_payload.position) begin
                           state_in = S_MOVE_RD;
                        end else begin
                           state_in = S_INS_PUT;
                        end
                     end
                  end
                  ACT_DELETE, ACT_READ: begin
                     if (access_bad) begin
                        status_in = ST_BAD_POS;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  ACT_LOCATE: begin
                     if (len_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else begin
                        j_in     = '0;
                        state_in = S_SCAN;
                     end
                  end
                  ACT_SORT: begin
                     if (len_ff == '0) begin
                        status_in = ST_NOT_FOUND;
                     end else if (len_ff != LEN_W'(1)) begin
                        j_in     = '0;
                        k_in     = LEN_W'(1);
                        state_in = S_SORT_LJ;
                     end
                  end
                  default: begin
                     // unused codes: report the current length only
                  end
               endcase
            end
         end

         S_FETCH: begin
            data_in = rd_data_ff;
            if (op_ff == ACT_DELETE) begin
               j_in = pos_ff;
               if (pos_ff < len_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  len_in   = len_dec;
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end

         // shift one entry: insert moves j-1 to j walking down, delete moves j to j-1 walking up
         S_MOVE_RD: begin
            if (op_ff == ACT_INSERT) begin
               rd_addr = j_dec[ADDR_W-1:0];
            end else begin
               rd_addr = j_ff[ADDR_W-1:0];
            end
            state_in = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            wr_en   = 1'b1;
            wr_data = rd_data_ff;
            if (op_ff == ACT_INSERT) begin
               wr_addr = j_ff[ADDR_W-1:0];
               j_in    = j_dec;
               if (j_ff > pos_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  state_in = S_INS_PUT;
               end
            end else begin
               wr_addr = j_dec[ADDR_W-1:0];
               j_in    = j_inc;
               if (j_inc < len_ff) begin
                  state_in = S_MOVE_RD;
               end else begin
                  len_in   = len_dec;
                  state_in = S_DONE;
               end
            end
         end

         S_INS_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_m1[ADDR_W-1:0];
            wr_data  = val_ff;
            len_in   = len_inc;
            state_in = S_DONE;
         end

         // compare entry j while fetching entry j+1
         S_SCAN: begin
            rd_addr = j_inc[ADDR_W-1:0];
            if (rd_data_ff == val_ff) begin
               found_in = j_inc;
               state_in = S_DONE;
            end else if (j_inc == len_ff) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_DONE;
            end else begin
               j_in = j_inc;
            end
         end

         // hold entry j in cur_ff, swap it with each later entry k that is smaller
         S_SORT_LJ: begin
            cur_in   = rd_data_ff;
            rd_addr  = k_ff[ADDR_W-1:0];
            state_in = S_SORT_CMP;
         end

         S_SORT_CMP: begin
            rd_addr = k_inc[ADDR_W-1:0];
            if (cur_ff > rd_data_ff) begin
               wr_en   = 1'b1;
               wr_addr = k_ff[ADDR_W-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data_ff;
            end
            k_in = k_inc;
            if (k_inc == len_ff) begin
               state_in = S_SORT_WJ;
            end
         end

         S_SORT_WJ: begin
            wr_en   = 1'b1;
            wr_addr = j_ff[ADDR_W-1:0];
            wr_data = cur_ff;
            rd_addr = j_inc[ADDR_W-1:0];
            j_in    = j_inc;
            k_in    = j_inc2;
            if (j_inc2 < len_ff) begin
               state_in = S_SORT_LJ;
            end else begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // advance only when the output register is free or being emptied
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in               = 1'b1;
               rsp_payload_in.status      = status_ff;
               rsp_payload_in.data_out    = data_ff;
               rsp_payload_in.found_index = found_ff;
               rsp_payload_in.length      = len_ff;
               state_in                   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      op_ff          <= op_in;
      pos_ff         <= pos_in;
      val_ff         <= val_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      cur_ff         <= cur_in;
      data_ff        <= data_in;
      status_ff      <= status_in;
      found_ff       <= found_in;
   end

endmodule

### rtl/sle_checker.sv
// Port-level checks for the sequential list engine and their bind.
module sle_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input sle_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input sle_pkg::rsp_type rsp_payload
);
   import sle_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // no result straight out of reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.length <= LEN_W'(CAPACITY))
      else $error("list length beyond capacity");

   // a match index lies inside the list and comes with a good status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.found_index != '0) |->
         (rsp_payload.status == ST_OK) && (rsp_payload.found_index <= rsp_payload.length))
      else $error("bad match index");

   // any error returns no data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status != ST_OK) |-> rsp_payload.data_out == '0)
      else $error("data returned with an error status");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (.*);
